@@ src/ptrd_pkg.sv @@
// ----------------------------------------------------------------------------
// ptrd_pkg
// shared codes and field widths for the piece table range delete block
// ----------------------------------------------------------------------------
package ptrd_pkg;

   localparam int FIELD_BITS = 24;
   localparam int COUNT_OUT_BITS = 6;

   localparam logic [1:0] MODE_APPEND = 2'd0;
   localparam logic [1:0] MODE_DELETE = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      STAT_DONE = 2'd0,
      STAT_IGNORED = 2'd1,
      STAT_FULL = 2'd2,
      STAT_BAD_INDEX = 2'd3
   } status_type;

endpackage

@@ src/ptrd_alu.sv @@
// ----------------------------------------------------------------------------
// ptrd_alu
// shared add / subtract unit used by the offset and length arithmetic steps of the sequencer
// ----------------------------------------------------------------------------
module ptrd_alu #(
   parameter int WIDTH = 34
) (
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   input  logic             op_sub,
   output logic [WIDTH-1:0] result
);

   logic [WIDTH-1:0] b_eff;

   // subtract as a + ~b + 1
   assign b_eff = op_sub ? ~op_b : op_b;
   assign result = op_a + b_eff + WIDTH'(op_sub);

endmodule

@@ src/piece_table_range_delete.sv @@
// ----------------------------------------------------------------------------
// piece_table_range_delete
// ordered piece table with append, range delete and read by index
// ----------------------------------------------------------------------------
// One item is worked at a time and gives exactly one result transfer. Append,
// read, unused-mode and reversed or empty range items need no table pass; a
// delete whose range is empty only after the end is clamped stops after the
// length sum pass. The table sits in one memory with a single registered
// read port, so the length sum pass, the locate walk and the tail shift of a
// delete each visit one entry at a time, and all offset and length arithmetic
// goes through one shared adder. A finished result is held in the output
// register, so the next item may be taken while it waits; an item that
// finishes while that register is still full waits in its last state until
// the receiver takes the older result.
// ----------------------------------------------------------------------------
module piece_table_range_delete
   import ptrd_pkg::*;
#(
   parameter int MAX_PIECES = 32,
   parameter int POS_BITS = 24
) (
   input  logic          clock,
   input  logic          reset,
   // request channel
   input  logic          req_tvalid,
   output logic          req_tready,
   // range_start[23:0] range_end[47:24] new_buffer[48] new_offset[72:49]
   // new_length[96:73], zero filled above
   input  logic [103:0]  req_tdata,
   // mode[1:0]
   input  logic [1:0]    req_tuser,
   // response channel
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // status[1:0] count_after[7:2] out_buffer[8] out_offset[32:9]
   // out_length[56:33], zero filled above
   output logic [63:0]   rsp_tdata
);

   localparam int PW = POS_BITS;
   localparam int IW = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
   localparam int CW = $clog2(MAX_PIECES + 1);
   // wide enough for any document position or summed length
   localparam int AW = ((PW > FIELD_BITS) ? PW : FIELD_BITS) + IW + 1;

   typedef enum logic [4:0] {
      S_IDLE, S_DISP, S_SUM_RD, S_SUM_ACC, S_CLAMP, S_LOC_RD, S_LOC_ADD,
      S_LOC_CMP, S_SO, S_EO, S_REM, S_NOFF, S_PLAN, S_SH_RD, S_SH_WR,
      S_WR_A, S_WR_B, S_RD_WAIT, S_FIN
   } state_type;

   state_type state_ff;

   // captured item
   logic [1:0]    mode_ff;
   logic [AW-1:0] start_ff, end_ff;
   logic          nbuf_ff;
   logic [PW-1:0] noff_ff, nlen_ff;

   // table bookkeeping
   logic [CW-1:0] cnt_ff;
   logic [IW-1:0] idx_ff;
   logic [AW-1:0] acc_ff, pe_ff, spos_ff, epos_ff;
   logic          fs_ff;
   logic [IW-1:0] sp_ff, ep_ff;
   logic          sp_src_ff, ep_src_ff;
   logic [PW-1:0] sp_off_ff, ep_off_ff, ep_len_ff;
   logic [PW-1:0] so_ff, eo_ff, rem_ff, noffb_ff;
   logic          keepl_ff, keepr_ff, up_ff;
   logic [IW-1:0] rp_ff, wp_ff;
   logic [CW-1:0] left_ff, newtot_ff;

   // result under construction and output register
   status_type    res_status_ff;
   logic          res_buf_ff;
   logic [PW-1:0] res_off_ff, res_len_ff;
   logic          rsp_valid_ff;
   logic [63:0]   rsp_data_ff;

   // piece memory, one write and one registered read port
   logic          mem_src [MAX_PIECES];
   logic [PW-1:0] mem_off [MAX_PIECES];
   logic [PW-1:0] mem_len [MAX_PIECES];
   logic          rd_src_ff;
   logic [PW-1:0] rd_off_ff, rd_len_ff;
   logic [IW-1:0] raddr, waddr;
   logic          we, wsrc;
   logic [PW-1:0] woff, wlen;

   // shared adder
   logic [AW-1:0] alu_a, alu_b, alu_res;
   logic          alu_sub;

   // helpers
   logic [AW-1:0] end_clamped;
   logic          last_entry;
   logic          keepl, keepr;
   logic [CW-1:0] knew, dst, src, tail;
   logic [CW-1:0] max_count;

   assign max_count = CW'(MAX_PIECES);
   assign end_clamped = (end_ff > acc_ff) ? acc_ff : end_ff;
   assign last_entry = (CW'(idx_ff) + CW'(1)) == cnt_ff;

   assign keepl = so_ff != '0;
   assign keepr = rem_ff != '0;
   assign knew = CW'(keepl) + CW'(keepr);
   assign dst = CW'(sp_ff) + knew;
   assign src = CW'(ep_ff) + CW'(1);
   assign tail = cnt_ff - src;

   ptrd_alu #(.WIDTH(AW)) u_alu (
      .op_a  (alu_a),
      .op_b  (alu_b),
      .op_sub(alu_sub),
      .result(alu_res)
   );

   // operand selection for the shared adder
   always_comb begin
      alu_a = acc_ff;
      alu_b = AW'(rd_len_ff);
      alu_sub = 1'b0;
      case (state_ff)
         S_SO: begin
            alu_a = start_ff;
            alu_b = spos_ff;
            alu_sub = 1'b1;
         end
         S_EO: begin
            alu_a = end_ff;
            alu_b = epos_ff;
            alu_sub = 1'b1;
         end
         S_REM: begin
            alu_a = AW'(ep_len_ff);
            alu_b = AW'(eo_ff);
            alu_sub = 1'b1;
         end
         S_NOFF: begin
            alu_a = AW'(ep_off_ff);
            alu_b = AW'(eo_ff);
         end
         default: begin
            alu_a = acc_ff;
            alu_b = AW'(rd_len_ff);
         end
      endcase
   end

   // memory port selection
   always_comb begin
      raddr = idx_ff;
      we = 1'b0;
      waddr = '0;
      wsrc = 1'b0;
      woff = '0;
      wlen = '0;
      case (state_ff)
         S_DISP: begin
            raddr = start_ff[IW-1:0];
            if (mode_ff == MODE_APPEND && cnt_ff < max_count && nlen_ff != '0) begin
               we = 1'b1;
               waddr = cnt_ff[IW-1:0];
               wsrc = nbuf_ff;
               woff = noff_ff;
               wlen = nlen_ff;
            end
         end
         S_SH_RD: begin
            raddr = rp_ff;
         end
         S_SH_WR: begin
            we = 1'b1;
            waddr = wp_ff;
            wsrc = rd_src_ff;
            woff = rd_off_ff;
            wlen = rd_len_ff;
         end
         S_WR_A: begin
            we = keepl_ff;
            waddr = sp_ff;
            wsrc = sp_src_ff;
            woff = sp_off_ff;
            wlen = so_ff;
         end
         S_WR_B: begin
            we = keepr_ff;
            waddr = sp_ff + IW'(keepl_ff);
            wsrc = ep_src_ff;
            woff = noffb_ff;
            wlen = rem_ff;
         end
         default: begin
            raddr = idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_src[waddr] <= wsrc;
         mem_off[waddr] <= woff;
         mem_len[waddr] <= wlen;
      end
      rd_src_ff <= mem_src[raddr];
      rd_off_ff <= mem_off[raddr];
      rd_len_ff <= mem_len[raddr];
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // output register drains; a finishing item reloads it below
         if (rsp_valid_ff && rsp_tready && state_ff != S_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  mode_ff <= req_tuser;
                  start_ff <= AW'(req_tdata[23:0]);
                  end_ff <= AW'(req_tdata[47:24]);
                  nbuf_ff <= req_tdata[48];
                  noff_ff <= PW'(req_tdata[72:49]);
                  nlen_ff <= PW'(req_tdata[96:73]);
                  state_ff <= S_DISP;
               end
            end
            S_DISP: begin
               res_status_ff <= STAT_IGNORED;
               res_buf_ff <= 1'b0;
               res_off_ff <= '0;
               res_len_ff <= '0;
               idx_ff <= '0;
               acc_ff <= '0;
               fs_ff <= 1'b0;
               state_ff <= S_FIN;
               case (mode_ff)
                  MODE_APPEND: begin
                     if (cnt_ff >= max_count) begin
                        res_status_ff <= STAT_FULL;
                     end else if (nlen_ff != '0) begin
                        res_status_ff <= STAT_DONE;
                        cnt_ff <= cnt_ff + CW'(1);
                     end
                  end
                  MODE_DELETE: begin
                     if (start_ff < end_ff) begin
                        state_ff <= (cnt_ff == '0) ? S_CLAMP : S_SUM_RD;
                     end
                  end
                  MODE_READ: begin
                     if (start_ff < AW'(cnt_ff)) begin
                        state_ff <= S_RD_WAIT;
                     end else begin
                        res_status_ff <= STAT_BAD_INDEX;
                     end
                  end
                  default: begin
                     res_status_ff <= STAT_IGNORED;
                  end
               endcase
            end
            S_RD_WAIT: begin
               res_status_ff <= STAT_DONE;
               res_buf_ff <= rd_src_ff;
               res_off_ff <= rd_off_ff;
               res_len_ff <= rd_len_ff;
               state_ff <= S_FIN;
            end
            // pass one: document length
            S_SUM_RD: begin
               state_ff <= S_SUM_ACC;
            end
            S_SUM_ACC: begin
               acc_ff <= alu_res;
               idx_ff <= idx_ff + IW'(1);
               state_ff <= last_entry ? S_CLAMP : S_SUM_RD;
            end
            S_CLAMP: begin
               end_ff <= end_clamped;
               acc_ff <= '0;
               idx_ff <= '0;
               state_ff <= (start_ff >= end_clamped) ? S_FIN : S_LOC_RD;
            end
            // pass two: find first and last touched pieces
            S_LOC_RD: begin
               state_ff <= S_LOC_ADD;
            end
            S_LOC_ADD: begin
               pe_ff <= alu_res;
               state_ff <= S_LOC_CMP;
            end
            S_LOC_CMP: begin
               if (!fs_ff && start_ff < pe_ff) begin
                  fs_ff <= 1'b1;
                  sp_ff <= idx_ff;
                  spos_ff <= acc_ff;
                  sp_src_ff <= rd_src_ff;
                  sp_off_ff <= rd_off_ff;
               end
               if (end_ff <= pe_ff) begin
                  ep_ff <= idx_ff;
                  epos_ff <= acc_ff;
                  ep_src_ff <= rd_src_ff;
                  ep_off_ff <= rd_off_ff;
                  ep_len_ff <= rd_len_ff;
                  state_ff <= (fs_ff || start_ff < pe_ff) ? S_SO : S_FIN;
               end else begin
                  acc_ff <= pe_ff;
                  idx_ff <= idx_ff + IW'(1);
                  state_ff <= last_entry ? S_FIN : S_LOC_RD;
               end
            end
            S_SO: begin
               so_ff <= alu_res[PW-1:0];
               state_ff <= S_EO;
            end
            S_EO: begin
               eo_ff <= alu_res[PW-1:0];
               state_ff <= S_REM;
            end
            S_REM: begin
               rem_ff <= alu_res[PW-1:0];
               state_ff <= S_NOFF;
            end
            S_NOFF: begin
               // offset wraps at the position width
               noffb_ff <= alu_res[PW-1:0];
               state_ff <= S_PLAN;
            end
            S_PLAN: begin
               keepl_ff <= keepl;
               keepr_ff <= keepr;
               up_ff <= dst > src;
               left_ff <= tail;
               newtot_ff <= dst + tail;
               if (dst > src) begin
                  // split grows the table, move the tail up from the top
                  rp_ff <= IW'(cnt_ff - CW'(1));
                  wp_ff <= IW'(cnt_ff);
               end else begin
                  rp_ff <= IW'(src);
                  wp_ff <= IW'(dst);
               end
               if (sp_ff == ep_ff && keepl && keepr && cnt_ff >= max_count) begin
                  res_status_ff <= STAT_FULL;
                  state_ff <= S_FIN;
               end else begin
                  state_ff <= (tail == '0) ? S_WR_A : S_SH_RD;
               end
            end
            S_SH_RD: begin
               state_ff <= S_SH_WR;
            end
            S_SH_WR: begin
               left_ff <= left_ff - CW'(1);
               if (up_ff) begin
                  rp_ff <= rp_ff - IW'(1);
                  wp_ff <= wp_ff - IW'(1);
               end else begin
                  rp_ff <= rp_ff + IW'(1);
                  wp_ff <= wp_ff + IW'(1);
               end
               state_ff <= (left_ff == CW'(1)) ? S_WR_A : S_SH_RD;
            end
            S_WR_A: begin
               state_ff <= S_WR_B;
            end
            S_WR_B: begin
               cnt_ff <= newtot_ff;
               res_status_ff <= STAT_DONE;
               state_ff <= S_FIN;
            end
            S_FIN: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff <= {7'd0, 24'(res_len_ff), 24'(res_off_ff), res_buf_ff,
                                  COUNT_OUT_BITS'(cnt_ff), res_status_ff};
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // the table never holds more pieces than it has room for
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= max_count)
      else $error("piece count beyond table size");

   // memory writes stay inside the table
   a_write_addr: assert property (@(posedge clock) disable iff (reset)
      we |-> (CW'(waddr) < max_count))
      else $error("piece write outside table");

   // a finished item lands in the output register when it is free
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && (!rsp_valid_ff || rsp_tready)) |=> rsp_valid_ff)
      else $error("result not presented");

   // memory is only written while an item is in work
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      we |-> (state_ff != S_IDLE && state_ff != S_FIN))
      else $error("piece write outside an item");

endmodule
